>>> hdl/sps_pkg.sv
`timescale 1ns / 1ps

package sps_pkg;

    typedef enum logic [1:0] {
        PROF_DAY       = 2'd0,
        PROF_NIGHT     = 2'd1,
        PROF_BACKLIGHT = 2'd2
    } t_profile;

    localparam logic [1:0] MODE_FORCE_DAY   = 2'd0;
    localparam logic [1:0] MODE_FORCE_NIGHT = 2'd1;
    localparam logic [1:0] MODE_AUTO        = 2'd2;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_DAY_NIGHT_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NIGHT_ENTER_LUMA   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NIGHT_EXIT_LUMA    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NIGHT_ENTER_LUX    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NIGHT_EXIT_LUX     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKLIGHT_MIN_DEV  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKLIGHT_MAX_LUMA = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_COUNT      = 3'd7;

    localparam logic [1:0]  RST_DAY_NIGHT_MODE     = MODE_AUTO;
    localparam logic [11:0] RST_NIGHT_ENTER_LUMA   = 12'd400;
    localparam logic [11:0] RST_NIGHT_EXIT_LUMA    = 12'd720;
    localparam logic [19:0] RST_NIGHT_ENTER_LUX    = 20'd128;
    localparam logic [19:0] RST_NIGHT_EXIT_LUX     = 20'd288;
    localparam logic [11:0] RST_BACKLIGHT_MIN_DEV  = 12'd560;
    localparam logic [11:0] RST_BACKLIGHT_MAX_LUMA = 12'd1440;
    localparam logic [7:0]  RST_CONFIRM_COUNT      = 8'd2;

    localparam logic [7:0] HITS_MAX = 8'd255;

    typedef struct packed {
        logic [11:0] avg_luma;
        logic [11:0] luma_spread;
        logic [19:0] env_lux;
    } t_sample;

    typedef struct packed {
        logic [1:0] profile;
        logic       switched;
        logic [7:0] brightness_level;
        logic [7:0] contrast_level;
        logic [7:0] saturation_level;
        logic [7:0] distortion_level;
        logic       gray_on;
        logic       hdr_on;
    } t_result;

    // Fixed picture settings of each profile.
    function automatic t_result profile_settings(input t_profile prof, input logic sw);
        t_result res;
        res.profile  = prof;
        res.switched = sw;
        res.gray_on  = 1'b0;
        res.hdr_on   = 1'b0;
        case (prof)
            PROF_NIGHT: begin
                res.brightness_level = 8'd140;
                res.contrast_level   = 8'd116;
                res.saturation_level = 8'd108;
                res.distortion_level = 8'd80;
                res.gray_on          = 1'b1;
            end
            PROF_BACKLIGHT: begin
                res.brightness_level = 8'd134;
                res.contrast_level   = 8'd132;
                res.saturation_level = 8'd128;
                res.distortion_level = 8'd120;
                res.hdr_on           = 1'b1;
            end
            default: begin
                res.profile          = PROF_DAY;
                res.brightness_level = 8'd128;
                res.contrast_level   = 8'd128;
                res.saturation_level = 8'd128;
                res.distortion_level = 8'd120;
            end
        endcase
        return res;
    endfunction

endpackage

>>> hdl/sps_in_if.sv
`timescale 1ns / 1ps

interface sps_in_if import sps_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hdl/sps_out_if.sv
`timescale 1ns / 1ps

interface sps_out_if import sps_pkg::*; ();
    logic    valid;
    logic    ready;
    t_result data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hdl/scene_profile_selector.sv
`timescale 1ns / 1ps
// Two register stages, the sample register and the result register; an accepted
// sample passes through both before its result is presented.
// Throughput: one sample per cycle; input ready drops only while both registers
// are full and the result is stalled.
// Reset (synchronous, active low) restores the register defaults, sets the
// profile to day and clears the pending count and both valid flags.

module scene_profile_selector import sps_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sps_in_if.sink                i_sample,
    sps_out_if.source             o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    logic [1:0]  r_mode;
    logic [11:0] r_enter_luma;
    logic [11:0] r_exit_luma;
    logic [19:0] r_enter_lux;
    logic [19:0] r_exit_lux;
    logic [11:0] r_bl_min_dev;
    logic [11:0] r_bl_max_luma;
    logic [7:0]  r_confirm;

    logic        r_s1_vld;
    t_sample     r_s1;
    logic        r_out_vld;
    t_result     r_out;

    t_profile    r_cur;
    t_profile    r_pend;
    logic [7:0]  r_hits;
    t_profile    n_cur;
    t_profile    n_pend;
    logic [7:0]  n_hits;
    logic        n_sw;
    t_profile    target;

    logic        out_free;
    logic        s1_adv;
    logic        in_acc;

    assign out_free         = !r_out_vld || o_result.ready;
    assign s1_adv           = r_s1_vld && out_free;
    assign i_sample.ready   = !r_s1_vld || out_free;
    assign in_acc           = i_sample.valid && i_sample.ready;
    assign o_result.valid   = r_out_vld;
    assign o_result.data    = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= RST_DAY_NIGHT_MODE;
            r_enter_luma  <= RST_NIGHT_ENTER_LUMA;
            r_exit_luma   <= RST_NIGHT_EXIT_LUMA;
            r_enter_lux   <= RST_NIGHT_ENTER_LUX;
            r_exit_lux    <= RST_NIGHT_EXIT_LUX;
            r_bl_min_dev  <= RST_BACKLIGHT_MIN_DEV;
            r_bl_max_luma <= RST_BACKLIGHT_MAX_LUMA;
            r_confirm     <= RST_CONFIRM_COUNT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DAY_NIGHT_MODE:     r_mode        <= i_cfg_wdata[1:0];
                CFG_NIGHT_ENTER_LUMA:   r_enter_luma  <= i_cfg_wdata[11:0];
                CFG_NIGHT_EXIT_LUMA:    r_exit_luma   <= i_cfg_wdata[11:0];
                CFG_NIGHT_ENTER_LUX:    r_enter_lux   <= i_cfg_wdata[19:0];
                CFG_NIGHT_EXIT_LUX:     r_exit_lux    <= i_cfg_wdata[19:0];
                CFG_BACKLIGHT_MIN_DEV:  r_bl_min_dev  <= i_cfg_wdata[11:0];
                CFG_BACKLIGHT_MAX_LUMA: r_bl_max_luma <= i_cfg_wdata[11:0];
                CFG_CONFIRM_COUNT:      r_confirm     <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Night uses the exit thresholds once it is the current profile.
    always_comb begin
        case (r_mode)
            MODE_FORCE_DAY:   target = PROF_DAY;
            MODE_FORCE_NIGHT: target = PROF_NIGHT;
            default: begin
                if (r_cur == PROF_NIGHT &&
                    (r_s1.avg_luma < r_exit_luma || r_s1.env_lux < r_exit_lux)) begin
                    target = PROF_NIGHT;
                end else if (r_cur != PROF_NIGHT &&
                    (r_s1.avg_luma <= r_enter_luma || r_s1.env_lux <= r_enter_lux)) begin
                    target = PROF_NIGHT;
                end else if (r_s1.luma_spread >= r_bl_min_dev &&
                             r_s1.avg_luma <= r_bl_max_luma) begin
                    target = PROF_BACKLIGHT;
                end else begin
                    target = PROF_DAY;
                end
            end
        endcase
    end

    always_comb begin
        n_cur  = r_cur;
        n_pend = target;
        n_hits = 8'd0;
        n_sw   = 1'b0;
        if (target != r_cur) begin
            if (target == r_pend) begin
                n_hits = (r_hits == HITS_MAX) ? r_hits : r_hits + 8'd1;
            end else begin
                n_hits = 8'd1;
            end
            if (n_hits >= r_confirm) begin
                n_cur  = target;
                n_hits = 8'd0;
                n_sw   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_cur     <= PROF_DAY;
            r_pend    <= PROF_DAY;
            r_hits    <= 8'd0;
        end else begin
            if (i_sample.ready) begin
                r_s1_vld <= in_acc;
            end
            if (out_free) begin
                r_out_vld <= r_s1_vld;
            end
            if (s1_adv) begin
                r_cur  <= n_cur;
                r_pend <= n_pend;
                r_hits <= n_hits;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= i_sample.data;
        end
        if (s1_adv) begin
            r_out <= profile_settings(n_cur, n_sw);
        end
    end

endmodule

>>> hdl/sps_checker.sv
`timescale 1ns / 1ps

module sps_checker import sps_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_out_valid,
    input logic    i_out_ready,
    input t_result i_out_data
);

    logic       out_acc;
    logic [1:0] r_last_prof;

    assign out_acc = i_out_valid && i_out_ready;

    // Profile of the last delivered result; the block starts in day.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_prof <= PROF_DAY;
        end else if (out_acc) begin
            r_last_prof <= i_out_data.profile;
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    a_switch_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> (i_out_data.switched == (i_out_data.profile != r_last_prof)))
        else $error("switched flag disagrees with profile change");

    a_mode_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_data.gray_on == (i_out_data.profile == PROF_NIGHT)) &&
                        (i_out_data.hdr_on == (i_out_data.profile == PROF_BACKLIGHT)))
        else $error("gray or HDR flag disagrees with profile");

    a_profile_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_data.profile == PROF_DAY ||
                        i_out_data.profile == PROF_NIGHT ||
                        i_out_data.profile == PROF_BACKLIGHT)
        else $error("undefined profile code delivered");

endmodule

bind scene_profile_selector sps_checker u_sps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_data  (o_result.data)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench import sps_pkg::*; ();

    localparam logic [1:0] MODE_RESERVED = 2'd3;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int SETTLE_CYCLES    = 4;
    localparam int unsigned LUMA_TOP = 4095;
    localparam int unsigned LUX_TOP  = 1048575;

    typedef enum int {
        SCENE_DARK,
        SCENE_BACKLIT,
        SCENE_BRIGHT,
        SCENE_EDGE,
        SCENE_NOISE
    } t_scene;

    class profile_scoreboard;
        logic [1:0]  mode;
        logic [11:0] enter_luma;
        logic [11:0] exit_luma;
        logic [19:0] enter_lux;
        logic [19:0] exit_lux;
        logic [11:0] min_dev;
        logic [11:0] max_luma;
        logic [7:0]  confirm;
        t_profile    current;
        t_profile    pending;
        logic [7:0]  hits;
        t_result     expected_results[$];
        int          mismatches;

        function new();
            mode       = RST_DAY_NIGHT_MODE;
            enter_luma = RST_NIGHT_ENTER_LUMA;
            exit_luma  = RST_NIGHT_EXIT_LUMA;
            enter_lux  = RST_NIGHT_ENTER_LUX;
            exit_lux   = RST_NIGHT_EXIT_LUX;
            min_dev    = RST_BACKLIGHT_MIN_DEV;
            max_luma   = RST_BACKLIGHT_MAX_LUMA;
            confirm    = RST_CONFIRM_COUNT;
            current    = PROF_DAY;
            pending    = PROF_DAY;
            hits       = 8'd0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_DAY_NIGHT_MODE:     mode       = value[1:0];
                CFG_NIGHT_ENTER_LUMA:   enter_luma = value[11:0];
                CFG_NIGHT_EXIT_LUMA:    exit_luma  = value[11:0];
                CFG_NIGHT_ENTER_LUX:    enter_lux  = value[19:0];
                CFG_NIGHT_EXIT_LUX:     exit_lux   = value[19:0];
                CFG_BACKLIGHT_MIN_DEV:  min_dev    = value[11:0];
                CFG_BACKLIGHT_MAX_LUMA: max_luma   = value[11:0];
                CFG_CONFIRM_COUNT:      confirm    = value[7:0];
                default: ;
            endcase
        endfunction

        // The reserved mode code behaves as automatic classification.
        function t_profile classify(t_sample s);
            if (mode == MODE_FORCE_DAY) return PROF_DAY;
            if (mode == MODE_FORCE_NIGHT) return PROF_NIGHT;
            if (current == PROF_NIGHT) begin
                if (s.avg_luma < exit_luma || s.env_lux < exit_lux) return PROF_NIGHT;
            end else if (s.avg_luma <= enter_luma || s.env_lux <= enter_lux) begin
                return PROF_NIGHT;
            end
            if (s.luma_spread >= min_dev && s.avg_luma <= max_luma) return PROF_BACKLIGHT;
            return PROF_DAY;
        endfunction

        function t_result settings_for(t_profile p, logic sw);
            t_result r;
            r.profile  = p;
            r.switched = sw;
            r.gray_on  = (p == PROF_NIGHT);
            r.hdr_on   = (p == PROF_BACKLIGHT);
            case (p)
                PROF_NIGHT: begin
                    {r.brightness_level, r.contrast_level, r.saturation_level,
                     r.distortion_level} = {8'd140, 8'd116, 8'd108, 8'd80};
                end
                PROF_BACKLIGHT: begin
                    {r.brightness_level, r.contrast_level, r.saturation_level,
                     r.distortion_level} = {8'd134, 8'd132, 8'd128, 8'd120};
                end
                default: begin
                    {r.brightness_level, r.contrast_level, r.saturation_level,
                     r.distortion_level} = {8'd128, 8'd128, 8'd128, 8'd120};
                end
            endcase
            return r;
        endfunction

        function void note_sample(t_sample s);
            t_profile target;
            logic     sw;
            target = classify(s);
            sw = 1'b0;
            if (target != current) begin
                if (target == pending) begin
                    if (hits < HITS_MAX) hits++;
                end else begin
                    pending = target;
                    hits = 8'd1;
                end
                if (hits >= confirm) begin
                    current = target;
                    hits = 8'd0;
                    sw = 1'b1;
                end
            end else begin
                pending = target;
                hits = 8'd0;
            end
            expected_results.push_back(settings_for(current, sw));
        endfunction

        function string show(t_result r);
            return $sformatf({"profile=%0d switched=%0d bright=%0d contrast=%0d ",
                              "sat=%0d dist=%0d gray=%0d hdr=%0d"},
                             r.profile, r.switched, r.brightness_level, r.contrast_level,
                             r.saturation_level, r.distortion_level, r.gray_on, r.hdr_on);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: result with no sample outstanding: %s", show(got));
                end
                return;
            end
            want = expected_results.pop_front();
            if (got.profile !== want.profile || got.switched !== want.switched ||
                got.brightness_level !== want.brightness_level ||
                got.contrast_level !== want.contrast_level ||
                got.saturation_level !== want.saturation_level ||
                got.distortion_level !== want.distortion_level ||
                got.gray_on !== want.gray_on || got.hdr_on !== want.hdr_on) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR at %0t: result mismatch", $realtime);
                    $display("  expected %s", show(want));
                    $display("  actual   %s", show(got));
                end
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    sps_in_if  sample_if ();
    sps_out_if result_if ();

    scene_profile_selector dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample    (sample_if),
        .o_result    (result_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    profile_scoreboard sb = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int idle_cycles    = 0;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Transaction monitor and watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (sample_if.valid === 1'b1 && sample_if.ready === 1'b1) begin
                sb.note_sample(sample_if.data);
            end
            if (result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
                sb.check_result(result_if.data);
            end
        end
        if ((sample_if.valid === 1'b1 && sample_if.ready === 1'b1) ||
            (result_if.valid === 1'b1 && result_if.ready === 1'b1)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("scene_profile_selector test failed");
            $finish;
        end
    end

    // Result side: random back-pressure, plus a long hold-off on request.
    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        result_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                result_if.ready <= 1'b0;
                hold_left--;
            end else if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = LONG_HOLD_CYCLES - 1;
                result_if.ready <= 1'b0;
            end else begin
                result_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_sample(t_sample s);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            sample_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        sample_if.valid <= 1'b1;
        sample_if.data  <= s;
        do @(posedge i_clk); while (sample_if.ready !== 1'b1);
    endtask

    task automatic send_levels(int unsigned luma, int unsigned dev, int unsigned lux);
        t_sample s;
        s.avg_luma    = 12'(luma);
        s.luma_spread = 12'(dev);
        s.env_lux     = 20'(lux);
        send_sample(s);
    endtask

    // The extra edge first lets the monitor log the last accepted sample.
    task automatic wait_drained();
        sample_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(posedge i_clk);
        sb.write_reg(idx, value);
    endtask

    task automatic set_config(input logic [1:0] mode,
                              input logic [11:0] enter_luma, exit_luma,
                              input logic [19:0] enter_lux, exit_lux,
                              input logic [11:0] min_dev, max_luma,
                              input logic [7:0] confirm);
        write_reg(CFG_DAY_NIGHT_MODE, CFG_DATA_W'(mode));
        write_reg(CFG_NIGHT_ENTER_LUMA, CFG_DATA_W'(enter_luma));
        write_reg(CFG_NIGHT_EXIT_LUMA, CFG_DATA_W'(exit_luma));
        write_reg(CFG_NIGHT_ENTER_LUX, enter_lux);
        write_reg(CFG_NIGHT_EXIT_LUX, exit_lux);
        write_reg(CFG_BACKLIGHT_MIN_DEV, CFG_DATA_W'(min_dev));
        write_reg(CFG_BACKLIGHT_MAX_LUMA, CFG_DATA_W'(max_luma));
        write_reg(CFG_CONFIRM_COUNT, CFG_DATA_W'(confirm));
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic int unsigned floor_of(int unsigned a, int unsigned b, int unsigned top);
        int unsigned v;
        v = (a > b) ? a : b;
        return (v > top) ? top : v;
    endfunction

    function automatic int unsigned jitter(int unsigned thr, int unsigned top);
        int v;
        v = int'(thr) + int'($urandom_range(0, 4)) - 2;
        if (v < 0) v = 0;
        if (v > int'(top)) v = int'(top);
        return v;
    endfunction

    // Shapes a sample towards one scene class under the current thresholds.
    function automatic t_sample make_sample(t_scene kind);
        t_sample     s;
        int unsigned lux_lo;
        int unsigned luma_lo;
        s.avg_luma    = 12'($urandom);
        s.luma_spread = 12'($urandom);
        s.env_lux     = 20'($urandom);
        lux_lo  = floor_of(32'(sb.exit_lux), sb.enter_lux + 1, LUX_TOP);
        luma_lo = floor_of(32'(sb.exit_luma), sb.enter_luma + 1, LUMA_TOP);
        case (kind)
            SCENE_DARK: begin
                if ($urandom_range(0, 1) == 0) s.avg_luma = 12'($urandom_range(0, sb.enter_luma));
                else s.env_lux = 20'($urandom_range(0, sb.enter_lux));
            end
            SCENE_BACKLIT: begin
                s.avg_luma    = 12'($urandom_range(luma_lo, sb.max_luma));
                s.luma_spread = 12'($urandom_range(sb.min_dev, LUMA_TOP));
                s.env_lux     = 20'($urandom_range(lux_lo, LUX_TOP));
            end
            SCENE_BRIGHT: begin
                s.avg_luma = 12'($urandom_range(floor_of(luma_lo, sb.max_luma + 1, LUMA_TOP),
                                                LUMA_TOP));
                s.env_lux  = 20'($urandom_range(lux_lo, LUX_TOP));
            end
            SCENE_EDGE: begin
                case ($urandom_range(0, 2))
                    0: s.avg_luma = 12'(jitter(32'(sb.enter_luma), LUMA_TOP));
                    1: s.avg_luma = 12'(jitter(32'(sb.exit_luma), LUMA_TOP));
                    default: s.avg_luma = 12'(jitter(32'(sb.max_luma), LUMA_TOP));
                endcase
                s.luma_spread = 12'(jitter(32'(sb.min_dev), LUMA_TOP));
                if ($urandom_range(0, 1) == 0) s.env_lux = 20'(jitter(32'(sb.enter_lux), LUX_TOP));
                else s.env_lux = 20'(jitter(32'(sb.exit_lux), LUX_TOP));
            end
            default: ;
        endcase
        return s;
    endfunction

    // Runs of one scene class, of random length up to three more than the confirmation count capped at six.
    task automatic run_scenes(int count);
        int     sent;
        int     run_len;
        int     cap;
        int     pick;
        t_scene kind;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) kind = SCENE_NOISE;
            else if (pick < 35) kind = SCENE_EDGE;
            else if (pick < 57) kind = SCENE_DARK;
            else if (pick < 79) kind = SCENE_BACKLIT;
            else kind = SCENE_BRIGHT;
            cap = (sb.confirm > 6) ? 6 : int'(sb.confirm);
            run_len = $urandom_range(1, cap + 3);
            repeat (run_len) begin
                if (sent < count) begin
                    send_sample(make_sample(kind));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = '0;
        cfg_wdata        = '0;
        sample_if.valid  = 1'b0;
        sample_if.data   = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed walk at the reset thresholds: entry, hysteresis, backlight,
        // an interrupted confirmation and the field extremes.
        send_levels(0, 0, 0);
        send_levels(0, 0, 0);
        send_levels(4095, 4095, 'hFFFFF);
        send_levels(719, 0, 'hFFFFF);
        send_levels(720, 0, 287);
        send_levels(720, 0, 288);
        send_levels(720, 0, 288);
        send_levels(400, 0, 'hFFFFF);
        send_levels(401, 0, 128);
        send_levels(1440, 560, 300);
        send_levels(1440, 4095, 'hFFFFF);
        send_levels(1441, 560, 'hFFFFF);
        send_levels(1440, 559, 'hFFFFF);
        send_levels(800, 600, 500);
        send_levels(4095, 0, 'hFFFFF);
        send_levels(800, 600, 500);
        send_levels(0, 0, 0);
        send_levels(0, 0, 0);
        send_levels(2730, 1365, 'hAAAAA);
        send_levels(1365, 2730, 'h55555);
        run_scenes(200);
        wait_drained();

        send_idle_pct = 57;
        set_config(MODE_AUTO, 12'($urandom), 12'($urandom), 20'($urandom), 20'($urandom),
                   12'($urandom), 12'($urandom), 8'($urandom_range(1, 5)));
        run_scenes(200);
        wait_drained();

        // Zero thresholds and no confirmation, first forced to day.
        send_idle_pct  = 0;
        recv_stall_pct = 57;
        set_config(MODE_FORCE_DAY, 12'd0, 12'd0, 20'd0, 20'd0, 12'd0, 12'd0, 8'd0);
        run_scenes(100);
        wait_drained();
        set_config(MODE_AUTO, 12'd0, 12'd0, 20'd0, 20'd0, 12'd0, 12'd0, 8'd0);
        run_scenes(100);
        wait_drained();

        send_idle_pct  = 38;
        recv_stall_pct = 38;
        set_config(MODE_AUTO, 12'hFFF, 12'hFFF, 20'hFFFFF, 20'hFFFFF, 12'hFFF, 12'hFFF, 8'd1);
        run_scenes(150);
        wait_drained();

        // Forced modes with the longest confirmation; one of the two runs
        // has to count all the way up before it switches.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_config(MODE_FORCE_NIGHT, RST_NIGHT_ENTER_LUMA, RST_NIGHT_EXIT_LUMA,
                   RST_NIGHT_ENTER_LUX, RST_NIGHT_EXIT_LUX, RST_BACKLIGHT_MIN_DEV,
                   RST_BACKLIGHT_MAX_LUMA, 8'd255);
        run_scenes(270);
        wait_drained();
        send_idle_pct = 57;
        write_reg(CFG_DAY_NIGHT_MODE, CFG_DATA_W'(MODE_FORCE_DAY));
        cfg_we <= 1'b0;
        @(posedge i_clk);
        run_scenes(270);
        wait_drained();

        send_idle_pct  = 38;
        recv_stall_pct = 38;
        set_config(MODE_RESERVED, 12'($urandom_range(100, 900)), 12'($urandom_range(300, 1500)),
                   20'($urandom_range(50, 600)), 20'($urandom_range(100, 1200)),
                   12'($urandom_range(200, 1200)), 12'($urandom_range(800, 2500)),
                   8'($urandom_range(0, 4)));
        run_scenes(150);
        wait_drained();

        // Hold the result side off long enough for the input to stall, then
        // let the sender pause until everything has come back.
        send_idle_pct  = 0;
        recv_stall_pct = 57;
        set_config(MODE_AUTO, RST_NIGHT_ENTER_LUMA, RST_NIGHT_EXIT_LUMA,
                   RST_NIGHT_ENTER_LUX, RST_NIGHT_EXIT_LUX, RST_BACKLIGHT_MIN_DEV,
                   RST_BACKLIGHT_MAX_LUMA, 8'd3);
        run_scenes(40);
        hold_req++;
        run_scenes(60);
        wait_drained();
        send_idle_pct  = 38;
        recv_stall_pct = 38;
        run_scenes(50);
        wait_drained();

        if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
            $display("scene_profile_selector test passed");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches,
                     sb.expected_results.size());
            $display("scene_profile_selector test failed");
        end
        $finish;
    end

endmodule
